>>> sv/assert_macros.svh
// assertion macros shared by the receiver modules
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant checked on every rising clock edge outside reset
`define SFR_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: invariant violated");

// consequence in the cycle after the antecedent, outside reset
`define SFR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

>>> sv/sfr_pkg.sv
// types and constants of the stuffed frame receiver
// no dependencies; used by all receiver modules by scoped names
package sfr_pkg;

   // line framing bytes
   localparam logic [7:0] HDR_A      = 8'h5E;
   localparam logic [7:0] HDR_B      = 8'h50;
   localparam logic [7:0] ESC_BYTE   = 8'h7D;
   localparam logic [7:0] START_BYTE = 8'h7E;
   localparam logic [7:0] ESC_XOR    = 8'h20;

   // primitive codes
   localparam logic [7:0] PR_ACK_POWERUP  = 8'h80;
   localparam logic [7:0] PR_ACK_VERSION  = 8'h81;
   localparam logic [7:0] PR_REQ_ADDR     = 8'h82;
   localparam logic [7:0] PR_END_DOWNLOAD = 8'h83;
   localparam logic [7:0] PR_CRC_ERR      = 8'h84;

   localparam logic [15:0] TIMEOUT_RESET = 16'd100;

   typedef enum logic [1:0] {
      OP_BYTE = 2'd0,
      OP_TICK = 2'd1,
      OP_SET  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_FRAME   = 2'd1,
      EV_TIMEOUT = 2'd2
   } event_type;

   typedef enum logic [3:0] {
      SS_IDLE        = 4'd0,
      SS_POWERUP_REQ = 4'd1,
      SS_POWERUP_ACK = 4'd2,
      SS_VERSION_REQ = 4'd3,
      SS_VERSION_ACK = 4'd4,
      SS_TRANSFER    = 4'd5,
      SS_DATA_REQ    = 4'd6,
      SS_COMPLETE    = 4'd7,
      SS_FAIL        = 4'd8
   } session_type;

   // what the framer hands to the session logic for one request
   typedef struct packed {
      logic        done;
      logic        timeout;
      logic        hdr_ok;
      logic [7:0]  prim;
      logic [31:0] addr;
   } frame_evt_type;

endpackage

>>> sv/stuffed_frame_receiver_with_session.sv
// top level of the byte-stuffed frame receiver with download session
// depends on sfr_pkg, sfr_frame, sfr_session and assert_macros.svh
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   operation, rx_byte, set_state, expected_state
//   rsp      out        rsp_valid/rsp_stall   event, session, reached, header, primitive, address
//   csr      in         csr_write             byte_timeout
//
// one request per cycle sustained while rsp_stall is low; a request is held in the input
// register, then its result in the result register until it is taken
// the result register frees up in the cycle it is taken, so a new result can enter as the old one leaves
// reset is synchronous and clears framing, timeout, session and address state
// byte_timeout resets to 100
`include "assert_macros.svh"

module stuffed_frame_receiver_with_session #(
   parameter int FRAME_BYTES = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_rx_byte,
   input  logic [3:0]  req_set_state,
   input  logic [3:0]  req_expected_state,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_res,
   output logic [3:0]  rsp_session_state,
   output logic        rsp_reached,
   output logic        rsp_header_ok,
   output logic [7:0]  rsp_primitive_res,
   output logic [31:0] rsp_address,
   input  logic        csr_write,
   input  logic [15:0] csr_byte_timeout
);

   logic        in_valid_ff, in_valid_in;
   logic [1:0]  op_ff;
   logic [7:0]  rx_ff;
   logic [3:0]  set_ff, exp_ff;
   logic [15:0] timeout_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  event_ff;
   logic [3:0]  session_ff;
   logic        reached_ff, header_ff;
   logic [7:0]  prim_ff;
   logic [31:0] addr_ff;

   logic        out_free, step, load;
   logic [3:0]  session_next;
   logic [31:0] address_next;
   logic        reached;
   sfr_pkg::frame_evt_type evt;
   sfr_pkg::event_type     event_code;

   // pipeline handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign load      = req_valid && !req_stall;

   assign in_valid_in  = load || (in_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && rsp_stall);

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= sfr_pkg::TIMEOUT_RESET;
      end else if (csr_write) begin
         timeout_ff <= csr_byte_timeout;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff  <= req_operation;
         rx_ff  <= req_rx_byte;
         set_ff <= req_set_state;
         exp_ff <= req_expected_state;
      end
   end

   sfr_frame #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_frame (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .operation   (op_ff),
      .rx_byte     (rx_ff),
      .byte_timeout(timeout_ff),
      .evt         (evt)
   );

   sfr_session u_session (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .operation     (op_ff),
      .set_state     (set_ff),
      .expected_state(exp_ff),
      .evt           (evt),
      .session_next  (session_next),
      .address_next  (address_next),
      .reached       (reached)
   );

   // event code
   always_comb begin
      event_code = sfr_pkg::EV_NONE;
      if (evt.done) begin
         event_code = sfr_pkg::EV_FRAME;
      end else if (evt.timeout) begin
         event_code = sfr_pkg::EV_TIMEOUT;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         event_ff   <= 2'(event_code);
         session_ff <= session_next;
         reached_ff <= reached;
         header_ff  <= evt.hdr_ok;
         prim_ff    <= evt.prim;
         addr_ff    <= address_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_res     = event_ff;
   assign rsp_session_state = session_ff;
   assign rsp_reached       = reached_ff;
   assign rsp_header_ok     = header_ff;
   assign rsp_primitive_res = prim_ff;
   assign rsp_address       = addr_ff;

   `SFR_ASSERT_NEXT(a_step_fills_rsp, clock, reset, step, rsp_valid_ff)
   `SFR_ASSERT(a_stall_only_when_full, clock, reset, !req_stall || (in_valid_ff && rsp_valid_ff))

endmodule

>>> sv/sfr_frame.sv
// unstuffing, frame store, byte count and idle timeout of the receiver
// depends on sfr_pkg and assert_macros.svh
`include "assert_macros.svh"

module sfr_frame #(
   parameter int FRAME_BYTES = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [1:0]            operation,
   input  logic [7:0]            rx_byte,
   input  logic [15:0]           byte_timeout,
   output sfr_pkg::frame_evt_type evt
);

   localparam int CW = $clog2(FRAME_BYTES + 1);

   logic [7:0]    store_ff [FRAME_BYTES];
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          esc_ff, esc_in;
   logic [15:0]   idle_ff, idle_in;

   logic          is_byte, is_tick, is_esc, store_en, timeout_hit, done;
   logic [7:0]    unstuffed;
   logic [CW-1:0] cnt_inc;
   logic [7:0]    eff [1:7];

   // operation decode
   always_comb begin
      is_byte = 1'b0;
      is_tick = 1'b0;
      case (sfr_pkg::op_type'(operation))
         sfr_pkg::OP_BYTE: is_byte = step;
         sfr_pkg::OP_TICK: is_tick = step;
         default:          ;
      endcase
   end

   // unstuff and advance the count
   assign is_esc      = (rx_byte == sfr_pkg::ESC_BYTE);
   assign unstuffed   = esc_ff ? (rx_byte ^ sfr_pkg::ESC_XOR) : rx_byte;
   assign store_en    = is_byte && !is_esc;
   assign cnt_inc     = cnt_ff + CW'((cnt_ff != '0) || (rx_byte == sfr_pkg::START_BYTE));
   assign done        = store_en && (cnt_inc == CW'(FRAME_BYTES));
   assign timeout_hit = is_tick && (idle_ff >= byte_timeout);

   // frame bytes as seen with the current byte forwarded
   always_comb begin
      for (int i = 1; i <= 7; i++) begin
         eff[i] = (cnt_ff == CW'(i)) ? unstuffed : store_ff[i];
      end
   end

   // control next state
   always_comb begin
      cnt_in  = cnt_ff;
      esc_in  = esc_ff;
      idle_in = idle_ff;
      if (is_byte) begin
         idle_in = '0;
         if (is_esc) begin
            esc_in = 1'b1;
         end else begin
            esc_in = 1'b0;
            cnt_in = done ? '0 : cnt_inc;
         end
      end else if (is_tick) begin
         if (timeout_hit) begin
            cnt_in  = '0;
            esc_in  = 1'b0;
            idle_in = '0;
         end else begin
            idle_in = idle_ff + 16'd1;
         end
      end
   end

   // result toward the session logic
   always_comb begin
      evt.done    = done;
      evt.timeout = timeout_hit;
      evt.hdr_ok  = done && (eff[1] == sfr_pkg::HDR_A) && (eff[2] == sfr_pkg::HDR_B);
      evt.prim    = done ? eff[3] : 8'd0;
      evt.addr    = {eff[7], eff[6], eff[5], eff[4]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         esc_ff  <= 1'b0;
         idle_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         esc_ff  <= esc_in;
         idle_ff <= idle_in;
      end
   end

   // frame store, one write port at the current count
   for (genvar g = 0; g < FRAME_BYTES; g++) begin : g_store
      always_ff @(posedge clock) begin
         if (store_en && (cnt_ff == CW'(g))) begin
            store_ff[g] <= unstuffed;
         end
      end
   end

   `SFR_ASSERT(a_cnt_bound, clock, reset, cnt_ff < CW'(FRAME_BYTES))
   `SFR_ASSERT_NEXT(a_done_clears, clock, reset, done, cnt_ff == '0 && !esc_ff)
   `SFR_ASSERT_NEXT(a_timeout_clears, clock, reset, timeout_hit, idle_ff == '0 && cnt_ff == '0)

endmodule

>>> sv/sfr_session.sv
// session state machine and captured address of the receiver
// depends on sfr_pkg
module sfr_session (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [1:0]             operation,
   input  logic [3:0]             set_state,
   input  logic [3:0]             expected_state,
   input  sfr_pkg::frame_evt_type evt,
   output logic [3:0]             session_next,
   output logic [31:0]            address_next,
   output logic                   reached
);

   sfr_pkg::session_type session_ff, session_in;
   logic [31:0]          addr_ff, addr_in;

   // next session from a decoded frame or a software set
   always_comb begin
      session_in = session_ff;
      addr_in    = addr_ff;
      if (evt.done && evt.hdr_ok) begin
         case (evt.prim)
            sfr_pkg::PR_ACK_POWERUP: begin
               if (session_ff == sfr_pkg::SS_POWERUP_REQ) session_in = sfr_pkg::SS_POWERUP_ACK;
            end
            sfr_pkg::PR_ACK_VERSION: begin
               if (session_ff == sfr_pkg::SS_VERSION_REQ) session_in = sfr_pkg::SS_VERSION_ACK;
            end
            sfr_pkg::PR_REQ_ADDR: begin
               if (session_ff == sfr_pkg::SS_TRANSFER) begin
                  session_in = sfr_pkg::SS_DATA_REQ;
                  addr_in    = evt.addr;
               end
            end
            sfr_pkg::PR_END_DOWNLOAD: session_in = sfr_pkg::SS_COMPLETE;
            sfr_pkg::PR_CRC_ERR:      session_in = sfr_pkg::SS_FAIL;
            default:                  ;
         endcase
      end else if (step && (sfr_pkg::op_type'(operation) == sfr_pkg::OP_SET)) begin
         if (set_state <= 4'(sfr_pkg::SS_FAIL)) begin
            session_in = sfr_pkg::session_type'(set_state);
         end
      end
   end

   assign session_next = 4'(session_in);
   assign address_next = addr_in;
   assign reached      = evt.done && (4'(session_in) == expected_state);

   always_ff @(posedge clock) begin
      if (reset) begin
         session_ff <= sfr_pkg::SS_IDLE;
         addr_ff    <= '0;
      end else if (step) begin
         session_ff <= session_in;
         addr_ff    <= addr_in;
      end
   end

endmodule

>>> test/tb.sv
// self-checking bench for stuffed_frame_receiver_with_session
// needs only sfr_pkg and the receiver rtl; drives random traffic and predicts each result
`timescale 1ns / 100ps

module tb;
   import sfr_pkg::*;

   localparam int FRAME_BYTES = 10;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PRINT_LIMIT = 40;
   localparam logic [1:0] OP_NONE = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx;
      logic [3:0] set_st;
      logic [3:0] exp_st;
   } req_item_type;

   typedef struct packed {
      event_type   ev;
      session_type sess;
      logic        reached;
      logic        hdr_ok;
      logic [7:0]  prim;
      logic [31:0] addr;
   } rsp_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = '0;
   logic [7:0]  req_rx_byte = '0;
   logic [3:0]  req_set_state = '0;
   logic [3:0]  req_expected_state = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_event_res;
   logic [3:0]  rsp_session_state;
   logic        rsp_reached;
   logic        rsp_header_ok;
   logic [7:0]  rsp_primitive_res;
   logic [31:0] rsp_address;
   logic        csr_write = 1'b0;
   logic [15:0] csr_byte_timeout = '0;

   // receiver state as the bench predicts it
   logic [7:0]  frame_buf [0:FRAME_BYTES-1];
   int          byte_cnt = 0;
   logic        esc_pending = 1'b0;
   logic [15:0] idle_ticks = '0;
   session_type session_now = SS_IDLE;
   logic [31:0] addr_now = '0;
   logic [15:0] timeout_cfg = TIMEOUT_RESET;

   rsp_item_type pending_results [$];

   int  error_count = 0;
   int  work_items = 0;
   int  frames_done = 0;
   int  good_headers = 0;
   int  timeouts_seen = 0;
   int  addr_captures = 0;
   int  quiet_cycles = 0;
   int  stall_left = 0;
   bit  gap_on = 1'b1;
   bit  stall_on = 1'b1;

   stuffed_frame_receiver_with_session #(.FRAME_BYTES(FRAME_BYTES)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_rx_byte        (req_rx_byte),
      .req_set_state      (req_set_state),
      .req_expected_state (req_expected_state),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_res      (rsp_event_res),
      .rsp_session_state  (rsp_session_state),
      .rsp_reached        (rsp_reached),
      .rsp_header_ok      (rsp_header_ok),
      .rsp_primitive_res  (rsp_primitive_res),
      .rsp_address        (rsp_address),
      .csr_write          (csr_write),
      .csr_byte_timeout   (csr_byte_timeout)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predict the result of one accepted request and advance the state
   function automatic rsp_item_type receive_step(input req_item_type r);
      rsp_item_type o;
      logic [7:0]   v;
      logic         hdr;
      o.ev = EV_NONE;
      o.reached = 1'b0;
      o.hdr_ok = 1'b0;
      o.prim = '0;
      case (r.op)
         OP_BYTE: begin
            idle_ticks = '0;
            if (r.rx == ESC_BYTE) begin
               esc_pending = 1'b1;
            end else begin
               v = esc_pending ? (r.rx ^ ESC_XOR) : r.rx;
               esc_pending = 1'b0;
               frame_buf[byte_cnt] = v;
               // only a raw start byte opens a frame
               if (byte_cnt > 0 || r.rx == START_BYTE)
                  byte_cnt++;
               if (byte_cnt >= FRAME_BYTES) begin
                  byte_cnt = 0;
                  hdr = (frame_buf[1] == HDR_A) && (frame_buf[2] == HDR_B);
                  o.hdr_ok = hdr;
                  o.prim = frame_buf[3];
                  frames_done++;
                  if (hdr) begin
                     good_headers++;
                     case (frame_buf[3])
                        PR_ACK_POWERUP:
                           if (session_now == SS_POWERUP_REQ) session_now = SS_POWERUP_ACK;
                        PR_ACK_VERSION:
                           if (session_now == SS_VERSION_REQ) session_now = SS_VERSION_ACK;
                        PR_REQ_ADDR:
                           if (session_now == SS_TRANSFER) begin
                              addr_now = {frame_buf[7], frame_buf[6], frame_buf[5], frame_buf[4]};
                              session_now = SS_DATA_REQ;
                              addr_captures++;
                           end
                        PR_END_DOWNLOAD: session_now = SS_COMPLETE;
                        PR_CRC_ERR: session_now = SS_FAIL;
                        default: ;
                     endcase
                  end
                  o.reached = (session_now == r.exp_st);
                  o.ev = EV_FRAME;
               end
            end
         end
         OP_TICK: begin
            if (idle_ticks >= timeout_cfg) begin
               byte_cnt = 0;
               esc_pending = 1'b0;
               idle_ticks = '0;
               o.ev = EV_TIMEOUT;
               timeouts_seen++;
            end else begin
               idle_ticks++;
            end
         end
         OP_SET: begin
            if (r.set_st <= SS_FAIL)
               session_now = session_type'(r.set_st);
         end
         default: ;
      endcase
      o.sess = session_now;
      o.addr = addr_now;
      return o;
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("[%0t] ERROR: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   // compare each taken result with the oldest prediction
   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            report_error("result arrived with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            check_field("event", 32'(rsp_event_res), 32'(want.ev));
            check_field("session", 32'(rsp_session_state), 32'(want.sess));
            check_field("reached", 32'(rsp_reached), 32'(want.reached));
            check_field("header_ok", 32'(rsp_header_ok), 32'(want.hdr_ok));
            check_field("primitive", 32'(rsp_primitive_res), 32'(want.prim));
            check_field("address", rsp_address, want.addr);
         end
      end
   end

   // result-side back-pressure: mostly short, now and then long
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_on && $urandom_range(0, 99) < 30) begin
         rsp_stall <= 1'b1;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // stop the run when no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      if (!gap_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // send one request and record its predicted result once accepted
   task automatic send_request(input logic [1:0] op, input logic [7:0] rx,
                               input logic [3:0] set_st, input logic [3:0] exp_st);
      req_item_type item;
      int           gap;
      item = '{op: op, rx: rx, set_st: set_st, exp_st: exp_st};
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_operation <= op;
      req_rx_byte <= rx;
      req_set_state <= set_st;
      req_expected_state <= exp_st;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_results.push_back(receive_step(item));
      if (!(op == OP_NONE || (op == OP_SET && set_st > SS_FAIL)))
         work_items++;
   endtask

   task automatic put_byte(input logic [7:0] b, input logic [3:0] exp_st);
      send_request(OP_BYTE, b, 4'($urandom), exp_st);
   endtask

   task automatic put_tick();
      send_request(OP_TICK, 8'($urandom), 4'($urandom), 4'($urandom));
   endtask

   task automatic put_set(input logic [3:0] s);
      send_request(OP_SET, 8'($urandom), s, 4'($urandom));
   endtask

   // send a frame body byte, escaping it where needed or by chance
   task automatic put_stuffed(input logic [7:0] b, input logic [3:0] exp_st);
      if (b == ESC_BYTE || (b == START_BYTE && $urandom_range(0, 1) == 0)
          || (b != (ESC_BYTE ^ ESC_XOR) && $urandom_range(0, 15) == 0)) begin
         put_byte(ESC_BYTE, exp_st);
         if ($urandom_range(0, 7) == 0)
            put_byte(ESC_BYTE, exp_st);
         put_byte(b ^ ESC_XOR, exp_st);
      end else begin
         put_byte(b, exp_st);
      end
   endtask

   // block must be idle before the timeout register changes
   task automatic write_timeout(input logic [15:0] v);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_byte_timeout <= v;
      csr_write <= 1'b1;
      @(posedge clock);
      csr_write <= 1'b0;
      timeout_cfg = v;
   endtask

   // primitive biased toward the one the current session waits for
   function automatic logic [7:0] pick_primitive();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2)
         return 8'($urandom);
      if (r < 6) begin
         case (session_now)
            SS_POWERUP_REQ: return PR_ACK_POWERUP;
            SS_VERSION_REQ: return PR_ACK_VERSION;
            SS_TRANSFER:    return PR_REQ_ADDR;
            default: ;
         endcase
      end
      return 8'($urandom_range(PR_ACK_POWERUP, PR_CRC_ERR));
   endfunction

   function automatic logic [3:0] likely_state(input logic [7:0] prim);
      case (prim)
         PR_ACK_POWERUP:  return SS_POWERUP_ACK;
         PR_ACK_VERSION:  return SS_VERSION_ACK;
         PR_REQ_ADDR:     return SS_DATA_REQ;
         PR_END_DOWNLOAD: return SS_COMPLETE;
         PR_CRC_ERR:      return SS_FAIL;
         default:         return session_now;
      endcase
   endfunction

   // one well-formed frame with random content, sometimes with line noise
   task automatic put_frame();
      logic [7:0] body [0:FRAME_BYTES-1];
      logic [3:0] exp_st;
      int         k;
      for (k = 0; k < FRAME_BYTES; k++)
         body[k] = 8'($urandom);
      body[1] = ($urandom_range(0, 99) < 85) ? HDR_A : 8'($urandom);
      body[2] = ($urandom_range(0, 99) < 85) ? HDR_B : 8'($urandom);
      body[3] = pick_primitive();
      exp_st = ($urandom_range(0, 4) == 0) ? 4'($urandom) : likely_state(body[3]);
      // junk on the line before the start
      if ($urandom_range(0, 9) == 0)
         put_byte(8'($urandom), exp_st);
      if ($urandom_range(0, 7) == 0)
         put_byte(ESC_BYTE, exp_st);
      put_byte(START_BYTE, exp_st);
      for (k = 1; k < FRAME_BYTES; k++) begin
         if ($urandom_range(0, 19) == 0)
            put_tick();
         put_stuffed(body[k], exp_st);
      end
   endtask

   // reset values, escapes, in-frame start byte, address capture, ignored requests
   task automatic test_frame_decode();
      gap_on = 1'b1;
      stall_on <= 1'b1;
      put_tick();
      put_set(SS_TRANSFER);
      put_byte(START_BYTE, SS_DATA_REQ);
      put_byte(HDR_A, SS_DATA_REQ);
      put_byte(HDR_B, SS_DATA_REQ);
      put_byte(PR_REQ_ADDR, SS_DATA_REQ);
      put_byte(8'hFF, SS_DATA_REQ);
      put_byte(ESC_BYTE, SS_DATA_REQ);
      put_byte(START_BYTE ^ ESC_XOR, SS_DATA_REQ);
      put_byte(8'h00, SS_DATA_REQ);
      put_byte(8'hA5, SS_DATA_REQ);
      put_byte(START_BYTE, SS_DATA_REQ);
      put_byte(ESC_BYTE, SS_DATA_REQ);
      put_byte(ESC_BYTE, SS_DATA_REQ);
      put_byte(ESC_BYTE ^ ESC_XOR, SS_DATA_REQ);
      send_request(OP_NONE, 8'hFF, 4'hF, 4'hF);
      put_set(4'hF);
      put_set(4'd9);
   endtask

   // zero timeout: ticks fire while idle and drop a partial frame
   task automatic test_timeout_edges();
      write_timeout(16'd0);
      put_tick();
      put_byte(ESC_BYTE, SS_IDLE);
      put_byte(START_BYTE, SS_IDLE);
      put_byte(8'h00, SS_IDLE);
      put_tick();
   endtask

   // mixed random traffic under one timeout setting
   task automatic test_random_traffic(input logic [15:0] timeout_val, input int n_items,
                                      input bit gaps, input bit stalls);
      int goal;
      int r;
      int lim;
      int k;
      write_timeout(timeout_val);
      gap_on = gaps;
      stall_on <= stalls;
      goal = work_items + n_items;
      while (work_items < goal) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            put_frame();
         end else if (r < 72) begin
            case ($urandom_range(0, 4))
               0: put_set(SS_POWERUP_REQ);
               1: put_set(SS_VERSION_REQ);
               2: put_set(SS_TRANSFER);
               default: put_set(4'($urandom));
            endcase
         end else if (r < 85) begin
            lim = (timeout_cfg > 128) ? 130 : int'(timeout_cfg) + 2;
            lim = ($urandom_range(0, 4) == 0) ? $urandom_range(1, lim) : $urandom_range(1, 4);
            for (k = 0; k < lim; k++)
               put_tick();
         end else if (r < 95) begin
            lim = $urandom_range(1, 4);
            for (k = 0; k < lim; k++)
               put_byte(8'($urandom), 4'($urandom));
         end else begin
            send_request(OP_NONE, 8'($urandom), 4'($urandom), 4'($urandom));
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_frame_decode();
      test_timeout_edges();
      test_random_traffic(16'hFFFF, 250, 1'b1, 1'b1);
      test_random_traffic(16'd2, 250, 1'b0, 1'b0);
      test_random_traffic(16'd0, 200, 1'b1, 1'b1);
      test_random_traffic(16'd1, 250, 1'b1, 1'b0);
      test_random_traffic(16'd5, 250, 1'b0, 1'b1);
      test_random_traffic(TIMEOUT_RESET, 250, 1'b1, 1'b1);
      test_random_traffic(16'($urandom_range(3, 300)), 250, 1'b1, 1'b1);
      // drain and let the pipeline settle
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0)
         report_error($sformatf("%0d results never arrived", pending_results.size()));
      $display("Run covered %0d requests: %0d frames (%0d with valid header), %0d timeouts,",
               work_items, frames_done, good_headers, timeouts_seen);
      $display("%0d address captures, byte timeouts from 0 to 65535; %0d errors",
               addr_captures, error_count);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
